>>> rtl/core/gag_pkg.sv
// ----------------------------------------------------------------------------
// gag_pkg: shared types and constants of the GNSS accuracy grader
// Item layouts, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package gag_pkg;

  // Datapath widths
  localparam int SIG_W  = 16;  // one sigma field
  localparam int SUM_W  = 33;  // lon^2 + lat^2
  localparam int RAD_W  = 34;  // radicand, padded to an even width
  localparam int ROOT_W = 17;  // integer root of the radicand
  localparam int REM_W  = 19;  // partial remainder of the root
  localparam int DEV_W  = 15;  // capped deviation
  localparam int CHG_W  = 16;  // signed window change
  localparam int QUAL_W = 3;
  localparam int CFG_W  = 15;  // widest register
  localparam int IDX_W  = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TINY_LIMIT  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CAP_VALUE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_LATCH_LIMIT = 2'd2;

  // Register reset values
  localparam logic [7:0]       TINY_LIMIT_RST  = 8'd3;
  localparam logic [DEV_W-1:0] CAP_VALUE_RST   = 15'd25344;
  localparam logic [DEV_W-1:0] LATCH_LIMIT_RST = 15'd2560;

  // Minimum deviation after reset and after a zero minimum (5 m)
  localparam logic [DEV_W-1:0] MIN_RESET = 15'd1280;

  // Quality codes
  localparam logic [QUAL_W-1:0] QUAL_NONE  = 3'd0;
  localparam logic [QUAL_W-1:0] QUAL_POOR  = 3'd1;
  localparam logic [QUAL_W-1:0] QUAL_FAIR  = 3'd2;
  localparam logic [QUAL_W-1:0] QUAL_GOOD  = 3'd3;
  localparam logic [QUAL_W-1:0] QUAL_BEST  = 3'd4;

  typedef struct packed {
    logic [SIG_W-1:0] lon_sigma;
    logic [SIG_W-1:0] lat_sigma;
  } in_item_t;

  typedef struct packed {
    logic [DEV_W-1:0]        deviation;
    logic [QUAL_W-1:0]       quality;
    logic signed [CHG_W-1:0] deviation_change;
    logic [DEV_W-1:0]        best_deviation;
    logic                    graded;
  } out_item_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

>>> rtl/core/gag_ram.sv
// ----------------------------------------------------------------------------
// gag_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gag_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/gag_sumsq.sv
// ----------------------------------------------------------------------------
// gag_sumsq: bit-serial sum of squares
// Forms lon^2 + lat^2 one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module gag_sumsq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [gag_pkg::SIG_W-1:0] lon,
  input  logic [gag_pkg::SIG_W-1:0] lat,
  output gag_pkg::unit_status_t    status,
  output logic [gag_pkg::SUM_W-1:0] sum
);
  import gag_pkg::*;

  localparam int CNT_W = $clog2(SIG_W);

  logic [SIG_W-1:0] lon_q;
  logic [SIG_W-1:0] lat_q;
  logic [SIG_W-1:0] lon_sh;
  logic [SIG_W-1:0] lat_sh;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  // Double the partial sum and add the operands picked by the current bits
  always_comb begin
    acc_next = {acc[SUM_W-2:0], 1'b0}
             + (lon_sh[SIG_W-1] ? SUM_W'(lon_q) : '0)
             + (lat_sh[SIG_W-1] ? SUM_W'(lat_q) : '0);
  end

  // Control: load on start, run one step per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SIG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: hold operands, shift multiplier bits, accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      lon_q  <= lon;
      lat_q  <= lat;
      lon_sh <= lon;
      lat_sh <= lat;
      acc    <= '0;
    end else if (busy) begin
      lon_sh <= {lon_sh[SIG_W-2:0], 1'b0};
      lat_sh <= {lat_sh[SIG_W-2:0], 1'b0};
      acc    <= acc_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign sum         = acc;

endmodule

>>> rtl/core/gag_isqrt.sv
// ----------------------------------------------------------------------------
// gag_isqrt: digit-serial integer square root
// Restoring root: takes two radicand bits and yields one root bit per cycle.
// ----------------------------------------------------------------------------
module gag_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [gag_pkg::RAD_W-1:0]  radicand,
  output gag_pkg::unit_status_t     status,
  output logic [gag_pkg::ROOT_W-1:0] root
);
  import gag_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int TRY_W = REM_W + 2;

  logic [RAD_W-1:0]  rad_sh;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root_q;
  logic [TRY_W-1:0]  rem_try;
  logic [TRY_W-1:0]  trial;
  logic              fits;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  // Bring down two bits and test 4*root + 1 against the remainder
  always_comb begin
    rem_try = {rem, rad_sh[RAD_W-1 -: 2]};
    trial   = TRY_W'({root_q, 2'b01});
    fits    = (rem_try >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift radicand, update remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root_q <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
      rem    <= fits ? REM_W'(rem_try - trial) : REM_W'(rem_try);
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign root        = root_q;

endmodule

>>> rtl/core/gnss_accuracy_grader_unit.sv
// ----------------------------------------------------------------------------
// gnss_accuracy_grader_unit: GNSS horizontal accuracy grader
// Computes the capped horizontal deviation, grades it against a running
// minimum and reports the change over a window of recent deviations.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_ready   | in_data  (in_item_t)
//   out     | output    | out_valid / out_ready | out_data (out_item_t)
//   cfg     | input     | cfg_we                | cfg_index, cfg_data
//
// An item passes from acceptance to its result in the output register through
// the bit-serial sum of squares, the load of the root unit, the digit-serial
// root, the cap, and the grading step, which also writes the window RAM once
// grading has latched. A new item is accepted once the previous one has been
// graded; its result may still wait in the output register. A stalled output
// holds the item in the grading step. Reset is synchronous; the window RAM
// needs no clearing since the full flag guards every use of its read data.
// ----------------------------------------------------------------------------
module gnss_accuracy_grader_unit #(
  parameter int WINDOW_DEPTH = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gag_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gag_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [gag_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gag_pkg::CFG_W-1:0]  cfg_data
);
  import gag_pkg::*;

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int CMP_W = DEV_W + 5;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BUSY  = 2'd1;
  localparam logic [1:0] S_GRADE = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;

  // Configuration registers
  logic [7:0]        tiny_limit;
  logic [DEV_W-1:0]  cap_value;
  logic [DEV_W-1:0]  latch_limit;

  // Grading state
  logic              latched;
  logic [DEV_W-1:0]  min_dev;
  logic [AW-1:0]     ptr;
  logic              full;
  logic signed [CHG_W-1:0] held_change;
  logic [DEV_W-1:0]  dev;

  // Serial units
  logic              accept;
  unit_status_t      sq_status;
  unit_status_t      rt_status;
  logic [SUM_W-1:0]  sum;
  logic [ROOT_W-1:0] root;

  // Window RAM
  logic              win_we;
  logic [AW-1:0]     ptr_inc;
  logic [AW-1:0]     rd_addr;
  logic [DEV_W-1:0]  oldest;

  // Grading step
  logic              commit;
  logic [DEV_W-1:0]  min_eff;
  logic [DEV_W-1:0]  min_next;
  logic              latched_next;
  logic signed [CHG_W-1:0] held_next;
  logic [QUAL_W-1:0] quality;
  logic [CMP_W-1:0]  dev_x2;
  logic [CMP_W-1:0]  dev_x1;
  logic [CMP_W-1:0]  min_x3;
  logic [CMP_W-1:0]  min_x4;
  logic [CMP_W-1:0]  min_x8;
  logic [CMP_W-1:0]  min_x20;
  logic              dev_cap;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_GRADE) && (!out_valid || out_ready);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_BUSY;
      S_BUSY:  if (rt_status.done) state_next = S_GRADE;
      S_GRADE: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      tiny_limit  <= TINY_LIMIT_RST;
      cap_value   <= CAP_VALUE_RST;
      latch_limit <= LATCH_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TINY_LIMIT:  tiny_limit  <= cfg_data[7:0];
        REG_CAP_VALUE:   cap_value   <= cfg_data[DEV_W-1:0];
        REG_LATCH_LIMIT: latch_limit <= cfg_data[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  gag_sumsq u_sumsq (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .lon    (in_data.lon_sigma),
    .lat    (in_data.lat_sigma),
    .status (sq_status),
    .sum    (sum)
  );

  gag_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_status.done),
    .radicand (RAD_W'(sum)),
    .status   (rt_status),
    .root     (root)
  );

  // Cap the root as it leaves the root unit
  assign dev_cap = (root < ROOT_W'(tiny_limit)) || (root >= ROOT_W'(cap_value));

  always_ff @(posedge clk) begin
    if (rt_status.done) begin
      dev <= dev_cap ? cap_value : root[DEV_W-1:0];
    end
  end

  // Window pointer: next write slot, and the slot after it is the new oldest
  assign ptr_inc = (ptr == AW'(WINDOW_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign rd_addr = ptr_inc;
  assign win_we  = commit && latched;

  gag_ram #(
    .WIDTH (DEV_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .we      (win_we),
    .wr_addr (ptr),
    .wr_data (dev),
    .rd_addr (rd_addr),
    .rd_data (oldest)
  );

  // Update minimum, latch and window change
  always_comb begin
    min_eff      = (min_dev == '0) ? MIN_RESET : min_dev;
    min_next     = min_eff;
    latched_next = latched;
    held_next    = held_change;
    if (!latched) begin
      if (dev < latch_limit) begin
        latched_next = 1'b1;
        min_next     = dev;
      end
    end else begin
      if (dev < min_eff) begin
        min_next = dev;
      end
      if (full) begin
        held_next = $signed({1'b0, dev}) - $signed({1'b0, oldest});
      end else begin
        held_next = '0;
      end
    end
  end

  // Grade against multiples of the updated minimum
  always_comb begin
    dev_x1  = CMP_W'(dev);
    dev_x2  = CMP_W'(dev) << 1;
    min_x4  = CMP_W'(min_next) << 2;
    min_x8  = CMP_W'(min_next) << 3;
    min_x3  = (CMP_W'(min_next) << 1) + CMP_W'(min_next);
    min_x20 = (CMP_W'(min_next) << 4) + min_x4;
    if (!latched) begin
      quality = QUAL_NONE;
    end else if (dev_x2 < min_x3) begin
      quality = QUAL_BEST;
    end else if (dev_x1 < min_x4) begin
      quality = QUAL_GOOD;
    end else if (dev_x1 < min_x8) begin
      quality = QUAL_FAIR;
    end else if (dev_x1 < min_x20) begin
      quality = QUAL_POOR;
    end else begin
      quality = QUAL_NONE;
    end
  end

  // Commit grading state
  always_ff @(posedge clk) begin
    if (rst) begin
      latched     <= 1'b0;
      min_dev     <= MIN_RESET;
      ptr         <= '0;
      full        <= 1'b0;
      held_change <= '0;
    end else if (commit) begin
      latched     <= latched_next;
      min_dev     <= min_next;
      held_change <= held_next;
      if (latched) begin
        ptr <= ptr_inc;
        if (ptr == AW'(WINDOW_DEPTH - 1)) begin
          full <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data.deviation        <= dev;
      out_data.quality          <= quality;
      out_data.deviation_change <= held_next;
      out_data.best_deviation   <= min_next;
      out_data.graded           <= latched_next;
    end
  end

endmodule

>>> rtl/core/gag_checker.sv
// ----------------------------------------------------------------------------
// gag_checker: port-level checks for the accuracy grader
// Watches the top level's ports and flags results that break the grading.
// ----------------------------------------------------------------------------
module gag_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input gag_pkg::out_item_t out_data
);
  import gag_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Keep the input open while no item is offered
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready && !in_valid |=> in_ready)
    else $error("input closed with no item taken");

  // Quality stays within the code range
  a_qual_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.quality <= QUAL_BEST)
    else $error("quality code out of range");

  // No grade before grading starts
  a_ungraded_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.graded |-> out_data.quality == QUAL_NONE)
    else $error("quality given before grading started");

  // Minimum never exceeds the deviation it was updated with
  a_best_le_dev: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.graded |-> out_data.best_deviation <= out_data.deviation)
    else $error("best deviation above current deviation");

endmodule

bind gnss_accuracy_grader_unit gag_checker u_gag_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> bench/gnss_accuracy_grader_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_accuracy_grader_unit_tb: self-checking bench for the accuracy grader
// Drives sigma pairs through the valid/ready input and checks every
// result against a cycle-free predictor of deviation, grade, window change
// and running minimum. Runs several register settings and idling profiles.
// ----------------------------------------------------------------------------
module gnss_accuracy_grader_unit_tb;
  import gag_pkg::*;

  localparam int                WIN_DEPTH  = 20;
  localparam int                LONG_HOLD  = 300;
  localparam logic [IDX_W-1:0]  REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;

  gnss_accuracy_grader_unit #(.WINDOW_DEPTH(WIN_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and register copies
  int unsigned lim_tiny  = 32'(TINY_LIMIT_RST);
  int unsigned lim_cap   = 32'(CAP_VALUE_RST);
  int unsigned lim_latch = 32'(LATCH_LIMIT_RST);
  bit          is_graded = 1'b0;
  int unsigned floor_dev = 32'(MIN_RESET);
  int unsigned recent_devs[$];
  int          last_change = 0;

  // Stimulus and expectations
  in_item_t  fix_queue[$];
  out_item_t pending_grades[$];

  // Idling profile and long hold-off requests
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int hold_asked = 0;
  int hold_done  = 0;
  int hold_left  = 0;

  // Bookkeeping
  int errors = 0;
  int fixes_sent = 0;
  int grades_checked = 0;
  int settings_used = 1;
  int rollovers = 0;
  int min_restores = 0;
  int quality_count[5] = '{default: 0};

  // Integer root of lon^2 + lat^2, built one bit at a time from the top
  function automatic int unsigned hypot_floor(logic [SIG_W-1:0] a, logic [SIG_W-1:0] b);
    logic [RAD_W-1:0]  sq;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    sq = RAD_W'(a) * RAD_W'(a) + RAD_W'(b) * RAD_W'(b);
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = root | (ROOT_W'(1) << i);
      if (RAD_W'(trial) * RAD_W'(trial) <= sq) root = trial;
    end
    return 32'(root);
  endfunction

  // Advance the predictor by one fix and return the expected grade
  function automatic out_item_t grade_fix(in_item_t fix);
    int unsigned       dev;
    logic [QUAL_W-1:0] q;
    out_item_t         r;
    dev = hypot_floor(fix.lon_sigma, fix.lat_sigma);
    if (dev < lim_tiny || dev >= lim_cap) dev = lim_cap;
    if (floor_dev == 0) begin
      floor_dev = 32'(MIN_RESET);
      min_restores++;
    end
    q = QUAL_NONE;
    if (!is_graded) begin
      if (dev < lim_latch) begin
        is_graded = 1'b1;
        floor_dev = dev;
      end
    end else begin
      if (dev < floor_dev) floor_dev = dev;
      if (2 * dev < 3 * floor_dev)   q = QUAL_BEST;
      else if (dev < 4 * floor_dev)  q = QUAL_GOOD;
      else if (dev < 8 * floor_dev)  q = QUAL_FAIR;
      else if (dev < 20 * floor_dev) q = QUAL_POOR;
      else                           q = QUAL_NONE;
      // Fill the window first, then slide it and report newest minus oldest
      if (recent_devs.size() < WIN_DEPTH) begin
        recent_devs.push_back(dev);
        last_change = 0;
      end else begin
        void'(recent_devs.pop_front());
        recent_devs.push_back(dev);
        last_change = int'(dev) - int'(recent_devs[0]);
        rollovers++;
      end
    end
    r.deviation        = dev[DEV_W-1:0];
    r.quality          = q;
    r.deviation_change = last_change[CHG_W-1:0];
    r.best_deviation   = floor_dev[DEV_W-1:0];
    r.graded           = is_graded;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Driver: present queued fixes, predict each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pending_grades.push_back(grade_fix(in_data));
        fixes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (fix_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= fix_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, then pick the next ready value
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_grades.size() == 0) begin
          note_failure("result with no fix outstanding");
        end else begin
          want = pending_grades.pop_front();
          grades_checked++;
          if (want.quality <= QUAL_BEST) quality_count[want.quality]++;
          if (out_data.deviation !== want.deviation ||
              out_data.quality !== want.quality ||
              out_data.deviation_change !== want.deviation_change ||
              out_data.best_deviation !== want.best_deviation ||
              out_data.graded !== want.graded)
            note_failure($sformatf(
              "got dev %0d q %0d chg %0d best %0d g %0d, want dev %0d q %0d chg %0d best %0d g %0d",
              out_data.deviation, out_data.quality, out_data.deviation_change,
              out_data.best_deviation, out_data.graded, want.deviation, want.quality,
              want.deviation_change, want.best_deviation, want.graded));
        end
      end
      // Hold off for a long stretch on request, else stall at random
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_asked != hold_done) begin
        hold_left <= LONG_HOLD;
        hold_done <= hold_done + 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  // Register write, mirrored into the predictor with the register's width
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_TINY_LIMIT:  lim_tiny  = 32'(val[7:0]);
      REG_CAP_VALUE:   lim_cap   = 32'(val[DEV_W-1:0]);
      REG_LATCH_LIMIT: lim_latch = 32'(val[DEV_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(int unsigned tiny, int unsigned cap, int unsigned latch_at);
    write_reg(REG_TINY_LIMIT, CFG_W'(tiny));
    write_reg(REG_CAP_VALUE, CFG_W'(cap));
    write_reg(REG_LATCH_LIMIT, CFG_W'(latch_at));
    settings_used++;
  endtask

  task automatic queue_fix(int unsigned lon, int unsigned lat);
    in_item_t f;
    f.lon_sigma = lon[SIG_W-1:0];
    f.lat_sigma = lat[SIG_W-1:0];
    fix_queue.push_back(f);
  endtask

  // Wait until every fix has been taken and every grade has come back
  task automatic drain();
    while (fix_queue.size() != 0 || in_valid || pending_grades.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_idling(int idle, int stall);
    sender_idle_pct    <= idle;
    receiver_stall_pct <= stall;
  endtask

  // Random fixes, mostly scaled around the current minimum to hit every grade
  function automatic in_item_t pick_fix(bit allow_zero);
    in_item_t    f;
    int unsigned hint;
    int unsigned target;
    int unsigned side;
    int          kind;
    kind = $urandom_range(0, 99);
    hint = is_graded ? floor_dev : lim_latch;
    if (hint == 0) hint = 32'(MIN_RESET);
    if (allow_zero && $urandom_range(0, 39) == 0) begin
      f = '0;
    end else if (kind < 15) begin
      f.lon_sigma = SIG_W'($urandom);
      f.lat_sigma = SIG_W'($urandom);
    end else if (kind < 30) begin
      f.lon_sigma = SIG_W'($urandom_range(0, 300));
      f.lat_sigma = SIG_W'($urandom_range(0, 300));
    end else if (kind < 85) begin
      target = hint * $urandom_range(5, 250) / 10 + $urandom_range(0, 3);
      if (target > 65535) target = 65535;
      side = $urandom_range(0, target >> 3);
      if ($urandom_range(0, 1) == 0) begin
        f.lon_sigma = target[SIG_W-1:0];
        f.lat_sigma = side[SIG_W-1:0];
      end else begin
        f.lon_sigma = side[SIG_W-1:0];
        f.lat_sigma = target[SIG_W-1:0];
      end
    end else begin
      f.lon_sigma = SIG_W'($urandom_range(0, 8191));
      f.lat_sigma = SIG_W'($urandom_range(0, 8191));
    end
    return f;
  endfunction

  // Feed a phase of random fixes, keeping the queue short so hints stay fresh
  task automatic run_random(int count, bit allow_zero, int hold_at, int pause_at);
    for (int n = 0; n < count; n++) begin
      while (fix_queue.size() >= 4) @(posedge clk);
      if (n == hold_at) hold_asked <= hold_asked + 1;
      if (n == pause_at) drain();
      fix_queue.push_back(pick_fix(allow_zero));
    end
    drain();
  endtask

  // Main sequence
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before grading at reset limits: extremes that never latch
    queue_fix(0, 0);
    queue_fix(65535, 65535);
    queue_fix(65535, 0);
    queue_fix(0, 65535);
    queue_fix(1, 1);
    drain();

    // Zero cap and zero latch limit; wide write masks tiny limit to 255
    write_reg(REG_TINY_LIMIT, 15'h7FFF);
    write_reg(REG_CAP_VALUE, 15'd0);
    write_reg(REG_LATCH_LIMIT, 15'd0);
    write_reg(REG_UNUSED, 15'h1234);
    settings_used++;
    queue_fix(100, 100);
    queue_fix(65535, 65535);
    queue_fix(0, 0);
    queue_fix(2, 7);
    drain();

    // Tiny limit masked to zero, widest cap and latch limit; walk the grades
    write_reg(REG_TINY_LIMIT, 15'h7F00);
    write_reg(REG_CAP_VALUE, 15'd32767);
    write_reg(REG_LATCH_LIMIT, 15'd32767);
    settings_used++;
    queue_fix(0, 0);        // latch on a zero deviation
    queue_fix(1280, 0);     // zero minimum restored, best grade
    queue_fix(1919, 0);
    queue_fix(0, 1920);     // good
    queue_fix(5119, 0);
    queue_fix(5120, 0);     // fair
    queue_fix(10239, 0);
    queue_fix(10240, 0);    // poor
    queue_fix(25599, 0);
    queue_fix(25600, 0);    // none
    queue_fix(65535, 65535);// capped
    queue_fix(1, 0);
    queue_fix(0, 0);        // zero minimum again
    queue_fix(2, 0);
    drain();

    // Reset limits, no idling, one long hold-off and one full pause
    set_limits(32'(TINY_LIMIT_RST), 32'(CAP_VALUE_RST), 32'(LATCH_LIMIT_RST));
    set_idling(0, 0);
    run_random(400, 1'b0, 60, 200);

    // Narrowest cap and widest tiny limit, sender mostly idle
    set_limits(255, 256, 1);
    set_idling(79, 0);
    run_random(250, 1'b0, -1, -1);

    // Open limits with zero tiny limit, receiver mostly stalling
    set_limits(0, 32767, 32767);
    set_idling(0, 79);
    run_random(450, 1'b1, -1, -1);

    // Random limits, both sides idling now and then
    set_limits($urandom_range(0, 255), $urandom_range(256, 32767), $urandom_range(1, 32767));
    set_idling(15, 15);
    run_random(400, 1'b1, -1, -1);

    repeat (50) @(posedge clk);
    if (pending_grades.size() != 0)
      note_failure($sformatf("%0d grades never arrived", pending_grades.size()));

    $display("Run covered %0d fixes and %0d checked grades over %0d register settings",
             fixes_sent, grades_checked, settings_used);
    $display("Grades 4..0: %0d %0d %0d %0d %0d, window slides %0d, minimum restores %0d",
             quality_count[4], quality_count[3], quality_count[2], quality_count[1],
             quality_count[0], rollovers, min_restores);
    if (errors == 0) begin
      $display("gnss_accuracy_grader_unit_tb passed");
    end else begin
      $display("gnss_accuracy_grader_unit_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("Timeout with %0d grades outstanding", pending_grades.size());
    $display("gnss_accuracy_grader_unit_tb failed");
    $finish;
  end

endmodule
